// File: hdl/sfr_pkg.sv
// sfr_pkg: shared constants, types and helpers for the stream find-and-replace block
// no dependencies
`default_nettype none

package sfr_pkg;

   localparam int MAX_PATTERN = 8;
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 4;
   localparam int WORD_W      = MAX_PATTERN * BYTE_W;
   localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
   localparam int IDX_W       = $clog2(MAX_PATTERN);

   // register map of the csr channel
   typedef enum logic [1:0] {
      CSR_PATTERN_BYTES      = 2'd0,
      CSR_PATTERN_LENGTH     = 2'd1,
      CSR_REPLACEMENT_BYTES  = 2'd2,
      CSR_REPLACEMENT_LENGTH = 2'd3
   } csr_index_type;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [CNT_W-1:0]  count_type;

   // lengths above the window depth act as a full window
   function automatic count_type clamp_len(input logic [LEN_W-1:0] v);
      count_type r;
      if (v > LEN_W'(MAX_PATTERN)) begin
         r = CNT_W'(MAX_PATTERN);
      end else begin
         r = CNT_W'(v);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hdl/sfr_ifs.sv
// sfr_ifs: valid/ready channel interfaces for request, response and csr transactions
// depends on sfr_pkg
`default_nettype none

interface sfr_req_if;
   import sfr_pkg::*;
   logic     valid;
   logic     ready;
   byte_type in_char;
   logic     in_last;
   modport source (output valid, output in_char, output in_last, input ready);
   modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface sfr_rsp_if;
   import sfr_pkg::*;
   logic     valid;
   logic     ready;
   byte_type out_char;
   logic     char_valid;
   logic     out_last;
   logic     any_replaced;
   modport source (output valid, output out_char, output char_valid, output out_last,
                   output any_replaced, input ready);
   modport sink   (input valid, input out_char, input char_valid, input out_last,
                   input any_replaced, output ready);
endinterface

interface sfr_csr_if;
   import sfr_pkg::*;
   logic                valid;
   logic                ready;
   csr_index_type       index;
   logic [WORD_W-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/stream_find_replace_all.sv
// stream_find_replace_all: a request transaction passes the input register, then the response buffer
// one request per cycle while each byte yields at most one output byte and the response side
// is ready; a byte that yields n output bytes (replacement or end-of-string flush, n <= 8) holds
// the next request until the one-byte-per-cycle response buffer is down to its last entry
// reset: synchronous, active high; clears the registers, window fill, replaced flag
// and both buffers, nothing else needs a pass after reset
`default_nettype none

module stream_find_replace_all (
   input  wire logic  clock,
   input  wire logic  reset,
   sfr_req_if.sink    req_ch,
   sfr_rsp_if.source  rsp_ch,
   sfr_csr_if.sink    csr_ch
);
   import sfr_pkg::*;

   // configuration registers
   logic [WORD_W-1:0] pat_bytes_ff;
   logic [LEN_W-1:0]  pat_len_ff;
   logic [WORD_W-1:0] rep_bytes_ff;
   logic [LEN_W-1:0]  rep_len_ff;

   // input register (one request transaction held here)
   logic              in_valid_ff;
   byte_type          in_char_ff;
   logic              in_last_ff;

   // match window state
   byte_type          win_ff [MAX_PATTERN];
   count_type         fill_ff;
   logic              flag_ff;

   // response buffer, drained one byte per cycle from entry 0 while the response side is ready
   byte_type          buf_ff [MAX_PATTERN];
   count_type         cnt_ff;
   logic              last_ff;
   logic              rep_ff;
   logic              cv_ff;

   // combinational results for the held byte
   count_type         plen;
   count_type         blen;
   count_type         f0;
   count_type         f1;
   logic              full;
   logic              hit;
   logic              marker;
   logic              done_rep;
   byte_type          win_w    [MAX_PATTERN];
   byte_type          win_in   [MAX_PATTERN];
   byte_type          list_w   [MAX_PATTERN];
   count_type         n_out;
   count_type         fill_in;
   logic              flag_in;

   logic              move;
   logic              pop;

   assign pop  = rsp_ch.valid && rsp_ch.ready;
   // held byte moves on once the buffer is empty or giving up its last entry
   assign move = in_valid_ff && ((cnt_ff == '0) || ((cnt_ff == count_type'(1)) && rsp_ch.ready));

   assign req_ch.ready = !in_valid_ff || move;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid        = (cnt_ff != '0);
   assign rsp_ch.out_char     = buf_ff[0];
   assign rsp_ch.char_valid   = cv_ff;
   assign rsp_ch.out_last     = last_ff && (cnt_ff == count_type'(1));
   assign rsp_ch.any_replaced = rep_ff && (cnt_ff == count_type'(1));

   // window compare and result list, all in one pass
   always_comb begin
      plen = clamp_len(pat_len_ff);
      blen = clamp_len(rep_len_ff);
      f0   = (fill_ff >= plen) ? '0 : fill_ff;
      f1   = f0 + count_type'(1);

      // new byte lands at the current fill position
      for (int i = 0; i < MAX_PATTERN; i++) begin
         win_w[i] = win_ff[i];
         if (f0[IDX_W-1:0] == IDX_W'(i)) begin
            win_w[i] = in_char_ff;
         end
      end

      full = (plen != '0) && (f1 == plen);
      hit  = full;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if ((CNT_W'(i) < plen) && (win_w[i] != pat_bytes_ff[i*BYTE_W +: BYTE_W])) begin
            hit = 1'b0;
         end
      end

      for (int i = 0; i < MAX_PATTERN; i++) begin
         list_w[i] = win_w[i];
         win_in[i] = win_w[i];
      end
      n_out   = '0;
      fill_in = f1;
      flag_in = flag_ff;

      if (plen == '0) begin
         // pass through, window untouched
         list_w[0] = in_char_ff;
         n_out     = count_type'(1);
         fill_in   = fill_ff;
         for (int i = 0; i < MAX_PATTERN; i++) begin
            win_in[i] = win_ff[i];
         end
      end else if (hit) begin
         // full match: emit the replacement text
         for (int i = 0; i < MAX_PATTERN; i++) begin
            list_w[i] = rep_bytes_ff[i*BYTE_W +: BYTE_W];
         end
         n_out   = blen;
         fill_in = '0;
         flag_in = 1'b1;
      end else if (full) begin
         // mismatch on a full window: oldest byte leaves, the rest slide down (all leave at end of string)
         n_out = in_last_ff ? plen : count_type'(1);
         for (int i = 0; i < MAX_PATTERN - 1; i++) begin
            win_in[i] = win_w[i+1];
         end
         fill_in = plen - count_type'(1);
      end else begin
         // window still filling; end of string flushes it
         n_out = in_last_ff ? f1 : '0;
      end

      // empty output on the final byte becomes a bare end marker
      marker = in_last_ff && (n_out == '0);
      if (marker) begin
         n_out     = count_type'(1);
         list_w[0] = '0;
      end

      done_rep = flag_in;
      if (in_last_ff) begin
         fill_in = '0;
         flag_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_bytes_ff <= '0;
         pat_len_ff   <= '0;
         rep_bytes_ff <= '0;
         rep_len_ff   <= '0;
         in_valid_ff  <= 1'b0;
         fill_ff      <= '0;
         flag_ff      <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            in_valid_ff <= 1'b1;
         end else if (move) begin
            in_valid_ff <= 1'b0;
         end

         if (move) begin
            fill_ff <= fill_in;
            flag_ff <= flag_in;
            cnt_ff  <= n_out;
         end else if (pop) begin
            cnt_ff  <= cnt_ff - count_type'(1);
         end

         // the user must write the csr only while idle; the block itself does not enforce it
         if (csr_ch.valid && csr_ch.ready) begin
            unique case (csr_ch.index)
               CSR_PATTERN_BYTES: begin
                  pat_bytes_ff <= csr_ch.data;
               end
               CSR_PATTERN_LENGTH: begin
                  pat_len_ff <= csr_ch.data[LEN_W-1:0];
                  fill_ff    <= '0;  // pending window bytes are dropped
               end
               CSR_REPLACEMENT_BYTES: begin
                  rep_bytes_ff <= csr_ch.data;
               end
               CSR_REPLACEMENT_LENGTH: begin
                  rep_len_ff <= csr_ch.data[LEN_W-1:0];
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_char_ff <= req_ch.in_char;
         in_last_ff <= req_ch.in_last;
      end

      if (move) begin
         for (int i = 0; i < MAX_PATTERN; i++) begin
            win_ff[i] <= win_in[i];
            buf_ff[i] <= list_w[i];
         end
         last_ff <= in_last_ff;
         rep_ff  <= in_last_ff && done_rep;
         cv_ff   <= !marker;
      end else if (pop) begin
         for (int i = 0; i < MAX_PATTERN - 1; i++) begin
            buf_ff[i] <= buf_ff[i+1];
         end
      end
   end

`ifndef NO_ASSERTIONS
   // end-of-string flags only ride on the final buffered byte
   a_last_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.out_last) |-> (cnt_ff == count_type'(1)))
      else $error("out_last shown before the final buffered byte");

   // a bare end marker is always the final response and carries no character
   a_marker: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.char_valid) |-> (rsp_ch.out_last && (rsp_ch.out_char == '0)))
      else $error("end marker without out_last or with a character");

   // the window never holds a whole pattern between bytes
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (plen != '0) |-> (fill_ff < plen))
      else $error("window fill reached the pattern length");

   // the held byte is never overwritten before it moves on
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !move) |-> !req_ch.ready)
      else $error("input register accepts while still occupied");
`endif

endmodule

`default_nettype wire

// File: sim/stream_find_replace_all_tb.sv
// stream_find_replace_all_tb: self-checking bench for the streaming find-and-replace-all block
// depends on sfr_pkg, sfr_ifs and stream_find_replace_all from hdl
// a scoreboard class predicts every output byte, plain tasks drive the three channels

module stream_find_replace_all_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sfr_pkg::*;

   localparam int TOTAL_CHARS  = 395;   // directed part plus random, at least this many in all
   localparam int STALL_LIMIT  = 2000;  // cycles with no transaction on any channel
   localparam int HOLD_CYCLES  = 300;   // long response back-pressure stretch
   localparam int HOLD_AFTER   = 150;   // results checked before the stretch starts
   localparam int SETTLE_WAIT  = 8;     // well past the block's latency

   // one predicted output byte of the rewritten string
   typedef struct packed {
      byte_type ch;
      logic     has_char;
      logic     last;
      logic     replaced;
   } out_byte_type;

   // predicts the rewritten stream and compares it with the response channel
   class rewrite_scoreboard;
      logic [WORD_W-1:0] pattern_word;
      logic [WORD_W-1:0] replace_word;
      logic [LEN_W-1:0]  pattern_len;
      logic [LEN_W-1:0]  replace_len;
      byte_type          window [MAX_PATTERN];
      int                fill;
      bit                replaced;
      out_byte_type      expected_q [$];
      int                mismatches;
      int                results_seen;

      function new();
         pattern_word = '0;
         replace_word = '0;
         pattern_len  = '0;
         replace_len  = '0;
         foreach (window[k]) window[k] = '0;
         fill         = 0;
         replaced     = 0;
         mismatches   = 0;
         results_seen = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [WORD_W-1:0] d);
         case (idx)
            CSR_PATTERN_BYTES:      pattern_word = d;
            CSR_PATTERN_LENGTH: begin
               pattern_len = d[LEN_W-1:0];
               fill        = 0;
            end
            CSR_REPLACEMENT_BYTES:  replace_word = d;
            CSR_REPLACEMENT_LENGTH: replace_len = d[LEN_W-1:0];
            default: ;
         endcase
      endfunction

      function void push_byte(byte_type c, logic v);
         out_byte_type o;
         o.ch       = c;
         o.has_char = v;
         o.last     = 1'b0;
         o.replaced = 1'b0;
         expected_q.push_back(o);
      endfunction

      // one accepted input character
      function void take_char(byte_type c, logic last);
         int plen;
         int blen;
         int first;
         int tail;
         bit hit;
         plen  = (pattern_len > MAX_PATTERN) ? MAX_PATTERN : int'(pattern_len);
         blen  = (replace_len > MAX_PATTERN) ? MAX_PATTERN : int'(replace_len);
         first = expected_q.size();
         if (plen == 0) begin
            push_byte(c, 1'b1);
         end else begin
            if (fill >= plen) fill = 0;
            window[fill] = c;
            fill++;
            if (fill == plen) begin
               hit = 1;
               for (int k = 0; k < plen; k++) begin
                  if (window[k] != pattern_word[8*k +: 8]) hit = 0;
               end
               if (hit) begin
                  for (int k = 0; k < blen; k++) push_byte(replace_word[8*k +: 8], 1'b1);
                  fill     = 0;
                  replaced = 1;
               end else begin
                  // oldest byte can no longer start a match
                  push_byte(window[0], 1'b1);
                  for (int k = 1; k < fill; k++) window[k-1] = window[k];
                  fill--;
               end
            end
         end
         if (last) begin
            for (int k = 0; k < fill; k++) push_byte(window[k], 1'b1);
            fill = 0;
            if (expected_q.size() == first) push_byte('0, 1'b0);
            tail = expected_q.size() - 1;
            expected_q[tail].last     = 1'b1;
            expected_q[tail].replaced = replaced;
            replaced = 0;
         end
      endfunction

      function void flag(string msg);
         if (mismatches < 10) $display("%t: %s", $realtime, msg);
         mismatches++;
      endfunction

      function void check_result(byte_type c, logic v, logic last, logic rep);
         out_byte_type want;
         results_seen++;
         if (expected_q.size() == 0) begin
            flag($sformatf("unexpected result char %02h valid %b last %b replaced %b",
                           c, v, last, rep));
            return;
         end
         want = expected_q.pop_front();
         if (want.ch !== c || want.has_char !== v || want.last !== last ||
             want.replaced !== rep) begin
            flag($sformatf("expected char %02h valid %b last %b replaced %b, got %02h %b %b %b",
                           want.ch, want.has_char, want.last, want.replaced,
                           c, v, last, rep));
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   sfr_req_if req_if ();
   sfr_rsp_if rsp_if ();
   sfr_csr_if csr_if ();

   stream_find_replace_all DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   rewrite_scoreboard board;

   // stimulus-side view of the current setting, used to steer strings toward matches
   logic [WORD_W-1:0] cur_pattern;
   int                cur_plen;
   bit                pattern_clean;   // no NUL byte inside the active pattern

   int  chars_sent;
   int  calm_req;
   int  calm_rsp;
   bit  rsp_hold;
   bit  hold_done;
   int  idle_cycles;

   // 4 ns clock
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // gap before the next transaction: 0..15, with stretches of back-to-back traffic
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   // characters near the pattern so partial matches and overlaps show up
   function automatic byte_type pick_char();
      int       slot;
      byte_type c;
      c = byte_type'($urandom_range(1, 255));
      if (cur_plen > 0 && $urandom_range(0, 3) != 0) begin
         slot = $urandom_range(0, cur_plen - 1);
         if (cur_pattern[8*slot +: 8] != 8'h00) c = cur_pattern[8*slot +: 8];
      end
      return c;
   endfunction

   // one request transaction; valid stays high across back-to-back characters
   task automatic send_char(byte_type ch, logic last);
      int gap;
      gap = rsp_hold ? 0 : draw_gap(calm_req);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.in_char <= ch;
      req_if.in_last <= last;
      do @(posedge clock); while (!req_if.ready);
      board.take_char(ch, last);
      chars_sent++;
   endtask

   // characters of a word, lowest byte first
   task automatic send_bytes(logic [WORD_W-1:0] word, int n, bit finish);
      for (int k = 0; k < n; k++) send_char(word[8*k +: 8], finish && k == n - 1);
   endtask

   // random string built from whole pattern copies and near-pattern characters
   task automatic send_text(int n, bit finish);
      byte_type text [$];
      while (text.size() < n) begin
         if (cur_plen > 0 && pattern_clean && $urandom_range(0, 2) == 0) begin
            for (int k = 0; k < cur_plen; k++) text.push_back(cur_pattern[8*k +: 8]);
         end else begin
            text.push_back(pick_char());
         end
      end
      foreach (text[k]) send_char(text[k], finish && k == text.size() - 1);
   endtask

   // wait until every predicted byte is out and the pipeline has drained
   task automatic settle();
      req_if.valid <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // one csr transaction; valid is left high for the next write
   task automatic csr_write(csr_index_type idx, logic [WORD_W-1:0] d);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= d;
      do @(posedge clock); while (!csr_if.ready);
      board.write_reg(idx, d);
   endtask

   // reprogram all four registers while the block is idle
   task automatic write_config(logic [WORD_W-1:0] pat, int plen,
                               logic [WORD_W-1:0] rep, int rlen);
      settle();
      csr_write(CSR_PATTERN_BYTES, pat);
      csr_write(CSR_PATTERN_LENGTH, WORD_W'(plen));
      csr_write(CSR_REPLACEMENT_BYTES, rep);
      csr_write(CSR_REPLACEMENT_LENGTH, WORD_W'(rlen));
      csr_if.valid <= 1'b0;
      cur_pattern   = pat;
      cur_plen      = (plen > MAX_PATTERN) ? MAX_PATTERN : plen;
      pattern_clean = 1;
      for (int k = 0; k < cur_plen; k++) begin
         if (pat[8*k +: 8] == 8'h00) pattern_clean = 0;
      end
   endtask

   // watchdog: ends the run when no channel moves for too long
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // response side: random stalls plus one long hold so the block backs up
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      rsp_hold  = 0;
      hold_done = 0;
      calm_rsp  = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (!hold_done && board.results_seen >= HOLD_AFTER) begin
            // sender keeps offering at full rate meanwhile
            rsp_if.ready <= 1'b0;
            rsp_hold = 1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold  = 0;
            hold_done = 1;
         end
         stall = draw_gap(calm_rsp);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         board.check_result(rsp_if.out_char, rsp_if.char_valid, rsp_if.out_last,
                            rsp_if.any_replaced);
      end
   end

   // main sequence: reset, directed cases, then random phases
   initial begin
      logic [WORD_W-1:0] pat;
      logic [WORD_W-1:0] rep;
      int                plen;
      int                rlen;
      int                base;
      int                pick;
      bit                narrow;
      board          = new();
      calm_req       = 0;
      chars_sent     = 0;
      cur_pattern    = '0;
      cur_plen       = 0;
      pattern_clean  = 1;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.in_char <= 8'h01;
      req_if.in_last <= 1'b0;
      csr_if.valid   <= 1'b0;
      csr_if.index   <= CSR_PATTERN_BYTES;
      csr_if.data    <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // registers at reset: pattern length zero passes characters through
      send_bytes(64'hFF01, 2, 1);

      // leftmost non-overlapping: "ababa" with "aba" gives "X" then "ba"
      write_config(64'h616261, 3, 64'h58, 1);
      send_bytes(64'h6162616261, 5, 1);
      // no match, window flushed at end of string
      send_bytes(64'h6261, 2, 1);

      // deletion leaves nothing: lone end marker with the replaced flag
      write_config(64'h6161, 2, 64'h0, 0);
      send_bytes(64'h6161, 2, 1);

      // lengths above the window depth clamp to eight, extreme byte values
      write_config(64'h01FF_8040_2010_0807, 15, 64'hFEDC_BA98_7654_3210, 12);
      send_bytes(64'h01FF_8040_2010_0807, 8, 1);

      // pattern holding a NUL byte never matches real text
      write_config(64'h0041, 2, 64'hFFFF_FFFF_FFFF_FFFF, 8);
      send_bytes(64'h4141, 2, 1);

      // one-byte pattern to eight-byte replacement: largest expansion per character
      write_config(64'h5A, 1, 64'h8877_6655_4433_2211, 8);
      send_bytes(64'h5A5A, 2, 1);

      // random phases, each with a fresh setting
      while (chars_sent < TOTAL_CHARS) begin
         narrow = $urandom_range(0, 1);
         base   = $urandom_range(1, 253);
         for (int k = 0; k < MAX_PATTERN; k++) begin
            pat[8*k +: 8] = narrow ? 8'(base + $urandom_range(0, 2))
                                   : 8'($urandom_range(0, 255));
         end
         pick = $urandom_range(0, 9);
         if (pick == 0) plen = 0;
         else if (pick == 1) plen = $urandom_range(9, 15);
         else plen = $urandom_range(1, 8);
         rlen = $urandom_range(0, 15);
         rep  = {$urandom, $urandom};
         write_config(pat, plen, rep, rlen);
         repeat ($urandom_range(2, 5)) send_text($urandom_range(1, 14), 1);
         // sometimes leave a string open so the length write drops the window
         if (chars_sent < 300 && $urandom_range(0, 3) == 0) begin
            send_text($urandom_range(1, 6), 0);
         end
      end

      settle();
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
